>>> src/pded_pkg.sv
// ----------------------------------------------------------------------------
// Percent-decimal escape decoder package
// Shared constants and the result group type passed from front to back.
// ----------------------------------------------------------------------------
package pded_pkg;

  // Character codes and the limit on an escaped byte value.
  localparam logic [7:0] Percent   = 8'h25;
  localparam logic [7:0] DigitZero = 8'h30;
  localparam logic [7:0] DigitNine = 8'h39;
  localparam int unsigned ByteLimit = 256;

  // Most result bytes that one input byte can produce.
  localparam int unsigned GroupBytes = 4;
  localparam int unsigned GroupIdxW  = $clog2(GroupBytes);

  // Depth of the group queue between the front and the back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // All result bytes caused by one accepted input byte.
  typedef struct packed {
    logic [GroupBytes-1:0][7:0] bytes;     // bytes in output order
    logic [GroupIdxW-1:0]       last_idx;  // index of the final valid byte
    logic                       last;      // final byte ends the packet
  } grp_t;

  // Handshake between the front and the queue.
  typedef struct packed {
    logic push;
    grp_t grp;
  } push_t;

endpackage

>>> src/percent_decimal_escape_decoder_top.sv
// A result byte passes the group queue, then the output register.
// Throughput: one input byte per cycle while the queue is not full; the back end
//   emits one byte per cycle while not stalled, sending an input's k bytes in turn.
// A four-group queue between front and back absorbs bursts of expanded bytes.
// Reset (asynchronous, active low) clears the escape state, queue and output valid.
// ----------------------------------------------------------------------------
// Percent-decimal escape decoder top level
// Replaces percent and one to three decimal digits with that nonzero byte value.
// ----------------------------------------------------------------------------
module percent_decimal_escape_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_packet_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  pded_pkg::push_t push;
  pded_pkg::grp_t  head;
  logic            q_full;
  logic            q_valid;
  logic            pop;

  // Front end: classification and escape state.
  pded_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .q_full_i        (q_full),
    .push_o          (push)
  );

  // Group queue.
  pded_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (q_full),
    .pop_i      (pop),
    .rd_valid_o (q_valid),
    .rd_grp_o   (head)
  );

  // Back end: byte serializer and output register.
  pded_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_valid_i  (q_valid),
    .rd_grp_i    (head),
    .pop_o       (pop),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule

>>> src/pded_front.sv
// ----------------------------------------------------------------------------
// Percent-decimal escape decoder front end
// Accepts payload bytes, tracks the pending escape and builds result groups.
// ----------------------------------------------------------------------------
module pded_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_packet_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            q_full_i,
  output pded_pkg::push_t push_o
);

  typedef enum logic [1:0] {
    PhNone,
    PhPct,
    PhOne,
    PhTwo
  } phase_e;

  // Bytes that resolving held text yields, up to three.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
  } held_t;

  phase_e     phase_q, phase_d, phase_mid;
  logic [3:0] first_q, first_d;
  logic [3:0] second_q, second_d;

  logic       accept;
  logic       is_digit;
  logic [3:0] digit;
  logic [9:0] three;
  logic       hit;
  logic       do_old;
  logic       emit_mid;
  logic [7:0] mid_byte;
  held_t      res_old, res_new;
  logic [2:0] n;
  pded_pkg::grp_t grp;

  // Resolve held text as if a non-digit followed.
  function automatic held_t resolve_f(input phase_e ph, input logic [3:0] fd,
                                      input logic [3:0] sd);
    held_t      r;
    logic [6:0] two;
    r   = '0;
    two = 7'(fd) * 7'd10 + 7'(sd);
    unique case (ph)
      PhNone: begin
        r.cnt = 2'd0;
      end
      PhPct: begin
        r.bytes[0] = pded_pkg::Percent;
        r.cnt      = 2'd1;
      end
      PhOne: begin
        if (fd != 4'd0) begin
          r.bytes[0] = {4'd0, fd};
          r.cnt      = 2'd1;
        end else begin
          r.bytes[0] = pded_pkg::Percent;
          r.bytes[1] = pded_pkg::DigitZero | {4'd0, fd};
          r.cnt      = 2'd2;
        end
      end
      PhTwo: begin
        if (two != 7'd0) begin
          r.bytes[0] = {1'b0, two};
          r.cnt      = 2'd1;
        end else begin
          r.bytes[0] = pded_pkg::Percent;
          r.bytes[1] = pded_pkg::DigitZero | {4'd0, fd};
          r.bytes[2] = pded_pkg::DigitZero | {4'd0, sd};
          r.cnt      = 2'd3;
        end
      end
      default: begin
        r.cnt = 2'd0;
      end
    endcase
    return r;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Classify the incoming byte.
  assign is_digit = (data_byte_i >= pded_pkg::DigitZero) &&
                    (data_byte_i <= pded_pkg::DigitNine);
  assign digit    = is_digit ? data_byte_i[3:0] : 4'd0;
  assign three    = 10'(first_q) * 10'd100 + 10'(second_q) * 10'd10 + 10'(digit);
  assign hit      = is_digit && (three != 10'd0) &&
                    (three < 10'(pded_pkg::ByteLimit));

  // Main decision on the held state and the new byte.
  always_comb begin
    phase_mid = phase_q;
    first_d   = first_q;
    second_d  = second_q;
    do_old    = 1'b0;
    emit_mid  = 1'b0;
    mid_byte  = data_byte_i;
    unique case (phase_q)
      PhNone: begin
        if (data_byte_i == pded_pkg::Percent) begin
          phase_mid = PhPct;
        end else begin
          emit_mid = 1'b1;
        end
      end
      PhPct, PhOne: begin
        if (is_digit) begin
          if (phase_q == PhPct) begin
            first_d   = digit;
            phase_mid = PhOne;
          end else begin
            second_d  = digit;
            phase_mid = PhTwo;
          end
        end else begin
          do_old = 1'b1;
          if (data_byte_i == pded_pkg::Percent) begin
            phase_mid = PhPct;
          end else begin
            phase_mid = PhNone;
            emit_mid  = 1'b1;
          end
        end
      end
      PhTwo: begin
        if (hit) begin
          phase_mid = PhNone;
          emit_mid  = 1'b1;
          mid_byte  = three[7:0];
        end else begin
          do_old = 1'b1;
          if (data_byte_i == pded_pkg::Percent) begin
            phase_mid = PhPct;
          end else begin
            phase_mid = PhNone;
            emit_mid  = 1'b1;
          end
        end
      end
      default: begin
        phase_mid = PhNone;
      end
    endcase
  end

  assign res_old = resolve_f(phase_q, first_q, second_q);
  assign res_new = resolve_f(phase_mid, first_d, second_d);
  assign phase_d = end_of_packet_i ? PhNone : phase_mid;

  // Assemble the result group in output order.
  always_comb begin
    grp = '0;
    n   = 3'd0;
    if (do_old) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < res_old.cnt) begin
          grp.bytes[n[1:0]] = res_old.bytes[k];
          n = n + 3'd1;
        end
      end
    end
    if (emit_mid) begin
      grp.bytes[n[1:0]] = mid_byte;
      n = n + 3'd1;
    end
    if (end_of_packet_i) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < res_new.cnt) begin
          grp.bytes[n[1:0]] = res_new.bytes[k];
          n = n + 3'd1;
        end
      end
    end
    grp.last_idx = 2'(n - 3'd1);
    grp.last     = end_of_packet_i;
  end

  assign push_o.push = accept && (n != 3'd0);
  assign push_o.grp  = grp;

  // Escape state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhNone;
      first_q  <= 4'd0;
      second_q <= 4'd0;
    end else if (accept) begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

`ifndef SYNTHESIS
  // A packet end leaves nothing held.
  a_eop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_packet_i |=> phase_q == PhNone)
    else $error("escape state held across packet end");

  // A packet end always yields at least one result byte.
  a_eop_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_packet_i |-> push_o.push)
    else $error("packet end produced no result");
`endif

endmodule

>>> src/pded_queue.sv
// ----------------------------------------------------------------------------
// Percent-decimal escape decoder group queue
// Small FIFO of result groups that decouples the front from the back.
// ----------------------------------------------------------------------------
module pded_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pded_pkg::push_t      push_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 rd_valid_o,
  output pded_pkg::grp_t       rd_grp_o
);

  pded_pkg::grp_t                     mem_q [pded_pkg::QueueDepth];
  logic [pded_pkg::QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [pded_pkg::QueueCntW-1:0]     cnt_q;
  logic                               wr_en, rd_en;

  assign full_o     = cnt_q == pded_pkg::QueueCntW'(pded_pkg::QueueDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_grp_o   = mem_q[rd_ptr_q];
  assign wr_en      = push_i.push && !full_o;
  assign rd_en      = pop_i && rd_valid_o;

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= push_i.grp;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // The front never offers a group while the queue is full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.push && full_o))
    else $error("group pushed into a full queue");
`endif

endmodule

>>> src/pded_back.sv
// ----------------------------------------------------------------------------
// Percent-decimal escape decoder back end
// Serializes queued result groups onto the output port one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
module pded_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rd_valid_i,
  input  pded_pkg::grp_t rd_grp_i,
  output logic           pop_o,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  output logic           out_valid_o,
  input  logic           out_stall_i
);

  logic [pded_pkg::GroupIdxW-1:0] idx_q;
  logic                           out_valid_q;
  logic [7:0]                     out_byte_q;
  logic                           out_last_q;
  logic                           load;
  logic                           at_end;

  assign load   = !out_valid_q || !out_stall_i;
  assign at_end = idx_q == rd_grp_i.last_idx;
  assign pop_o  = load && rd_valid_i && at_end;

  // Output register and position within the head group.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= rd_valid_i;
      if (rd_valid_i) begin
        idx_q <= at_end ? '0 : idx_q + 1'b1;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load && rd_valid_i) begin
      out_byte_q <= rd_grp_i.bytes[idx_q];
      out_last_q <= rd_grp_i.last && at_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  // Finishing a group always places its final byte on the output.
  a_pop_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_o && (out_last_o == $past(rd_grp_i.last)))
    else $error("group retired without its final byte");
`endif

endmodule
